>>> design/wssid_pkg.sv
// Package for the WLAN management frame SSID extractor.
// Holds frame class and element phase codes, frame offsets and the character filter.
// Depends on nothing.
`timescale 1ns / 1ps

package wssid_pkg;

	localparam int MAX_FRAME_BYTES = 4095;
	localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

	localparam int BODY_PROBE_REQ = 24;
	localparam int BODY_BEACON    = 36;
	localparam int ADDR_FIRST     = 10;
	localparam int ADDR_LAST      = 15;

	localparam logic [1:0] FTYPE_MGMT      = 2'd0;
	localparam logic [3:0] SUBTYPE_PROBE_REQ = 4'd4;
	localparam logic [3:0] SUBTYPE_PROBE_RSP = 4'd5;
	localparam logic [3:0] SUBTYPE_BEACON    = 4'd8;

	localparam logic [7:0] EID_SSID       = 8'd0;
	localparam logic [7:0] CHAR_LOW       = 8'd32;
	localparam logic [7:0] CHAR_HIGH      = 8'd126;
	localparam logic [7:0] CHAR_SUBST     = 8'h2E;

	typedef enum logic [1:0] {
		CLS_IGNORED   = 2'd0,
		CLS_SHORT     = 2'd1,
		CLS_PROBE_REQ = 2'd2,
		CLS_BEACON    = 2'd3
	} frame_class_t;

	typedef enum logic [1:0] {
		PH_ID    = 2'd0,
		PH_LEN   = 2'd1,
		PH_VALUE = 2'd2,
		PH_DONE  = 2'd3
	} elem_phase_t;

	typedef enum logic {
		KIND_CHAR    = 1'b0,
		KIND_SUMMARY = 1'b1
	} result_kind_t;

	function automatic logic [7:0] printable(input logic [7:0] c);
		return (c >= CHAR_LOW && c <= CHAR_HIGH) ? c : CHAR_SUBST;
	endfunction

endpackage

>>> design/wssid_if.sv
// Valid/ready channel interfaces of the SSID extractor: frame bytes in, results out.
// Depends on nothing.
`timescale 1ns / 1ps

interface wssid_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;
	logic       mgmt_packet;

	modport source (output valid, frame_byte, last_byte, mgmt_packet, input ready);
	modport sink   (input valid, frame_byte, last_byte, mgmt_packet, output ready);
endinterface

interface wssid_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  ssid_char;
	logic [1:0]  frame_class;
	logic [47:0] source_addr;
	logic        ssid_found;
	logic [7:0]  ssid_length;
	logic [31:0] packet_count;

	modport source (output valid, result_kind, ssid_char, frame_class, source_addr,
		ssid_found, ssid_length, packet_count, input ready);
	modport sink   (input valid, result_kind, ssid_char, frame_class, source_addr,
		ssid_found, ssid_length, packet_count, output ready);
endinterface

>>> design/wlan_mgmt_frame_ssid_extractor.sv
// Streaming 802.11 management frame parser: classifies frames, captures the
// source address and emits the first SSID element. Depends on wssid_pkg and
// the channel interfaces in wssid_if.sv.
`timescale 1ns / 1ps

// Usage
//   frame  : one frame byte per request, starting at frame control; last_byte
//            marks the final byte, mgmt_packet is sampled with the first byte.
//   result : one SSID character per SSID value byte, and one summary request
//            on the last byte of each frame (a character on the last byte is
//            carried inside the summary). Nothing comes out while disabled.
//   cfg_we / cfg_data : write of the enable bit; write only while idle.
// Path: a byte taken lands in the input register and is parsed into the
//   result register once that register is empty or being taken; the result
//   is then held there until the receiver takes it.
// Throughput: one byte per cycle while result is not stalled, set by the
//   single parse step between the input register and the result register.
// Reset: clears enable, the packet counter, the frame state and both
//   registers' valid bits.
// Stall: while result is held, the input register fills and then ready drops;
//   no request is lost or repeated.
module wlan_mgmt_frame_ssid_extractor (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_data,
	wssid_frame_if.sink    frame,
	wssid_result_if.source result
);

	localparam int PW = wssid_pkg::POS_W;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       mgmt_s1;

	// configuration and frame state
	logic                     enable_q;
	logic [PW-1:0]            pos_q;
	wssid_pkg::frame_class_t  class_q;
	logic [47:0]              addr_q;
	wssid_pkg::elem_phase_t   phase_q;
	logic [7:0]               eid_q;
	logic [7:0]               rem_q;
	logic                     found_q;
	logic [7:0]               slen_q;
	logic [31:0]              count_q;
	logic                     mseen_q;

	// result register
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  char_q;
	logic [1:0]  cls_out_q;
	logic [47:0] addr_out_q;
	logic        found_out_q;
	logic [7:0]  len_out_q;
	logic [31:0] count_out_q;

	logic advance;

	// next state
	logic [PW-1:0]            pos_d;
	wssid_pkg::frame_class_t  class_d;
	logic [47:0]              addr_d;
	wssid_pkg::elem_phase_t   phase_d;
	logic [7:0]               eid_d;
	logic [7:0]               rem_d;
	logic                     found_d;
	logic [7:0]               slen_d;
	logic [31:0]              count_d;
	logic                     mseen_d;

	// result candidate
	logic        emit;
	logic        kind_d;
	logic [7:0]  char_d;
	logic [1:0]  cls_out_d;
	logic [47:0] addr_out_d;
	logic        found_out_d;
	logic [7:0]  len_out_d;

	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign frame.ready = !valid_s1 || advance;

	always_comb begin
		logic                    first;
		logic [1:0]              ftype;
		logic [3:0]              fsub;
		logic                    have_char;
		logic [7:0]              ch;
		logic [PW-1:0]           body;
		logic [7:0]              rem_dec;
		wssid_pkg::frame_class_t cls_sum;

		first     = (pos_q == '0);
		ftype     = byte_s1[3:2];
		fsub      = byte_s1[7:4];
		have_char = 1'b0;
		ch        = '0;
		rem_dec   = '0;
		body      = '0;
		cls_sum   = wssid_pkg::CLS_IGNORED;

		pos_d   = pos_q;
		class_d = class_q;
		addr_d  = addr_q;
		phase_d = phase_q;
		eid_d   = eid_q;
		rem_d   = rem_q;
		found_d = found_q;
		slen_d  = slen_q;
		count_d = count_q;
		mseen_d = mseen_q;

		emit        = 1'b0;
		kind_d      = wssid_pkg::KIND_CHAR;
		char_d      = '0;
		cls_out_d   = '0;
		addr_out_d  = '0;
		found_out_d = 1'b0;
		len_out_d   = '0;

		if (!enable_q) begin
			pos_d = '0;
		end else begin
			// start of frame: drop old frame state, classify from frame control
			if (first) begin
				class_d = wssid_pkg::CLS_IGNORED;
				addr_d  = '0;
				phase_d = wssid_pkg::PH_ID;
				eid_d   = '0;
				rem_d   = '0;
				found_d = 1'b0;
				slen_d  = '0;
				mseen_d = mgmt_s1;
				if (mgmt_s1) begin
					count_d = count_q + 32'd1;
					if (ftype == wssid_pkg::FTYPE_MGMT) begin
						if (fsub == wssid_pkg::SUBTYPE_PROBE_REQ)
							class_d = wssid_pkg::CLS_PROBE_REQ;
						else if (fsub == wssid_pkg::SUBTYPE_PROBE_RSP ||
							fsub == wssid_pkg::SUBTYPE_BEACON)
							class_d = wssid_pkg::CLS_BEACON;
					end
				end
			end

			if (pos_q < PW'(wssid_pkg::MAX_FRAME_BYTES)) begin
				if (pos_q >= PW'(wssid_pkg::ADDR_FIRST) && pos_q <= PW'(wssid_pkg::ADDR_LAST))
					addr_d = {addr_d[39:0], byte_s1};

				body = (class_d == wssid_pkg::CLS_PROBE_REQ) ?
					PW'(wssid_pkg::BODY_PROBE_REQ) : PW'(wssid_pkg::BODY_BEACON);

				if ((class_d == wssid_pkg::CLS_PROBE_REQ || class_d == wssid_pkg::CLS_BEACON)
					&& pos_q >= body) begin
					unique case (phase_d)
						wssid_pkg::PH_ID: begin
							eid_d   = byte_s1;
							phase_d = wssid_pkg::PH_LEN;
						end
						wssid_pkg::PH_LEN: begin
							rem_d = byte_s1;
							if (eid_d == wssid_pkg::EID_SSID) begin
								slen_d = byte_s1;
								if (byte_s1 == 8'd0) begin
									found_d = 1'b1;
									phase_d = wssid_pkg::PH_DONE;
								end else begin
									phase_d = wssid_pkg::PH_VALUE;
								end
							end else begin
								phase_d = (byte_s1 == 8'd0) ? wssid_pkg::PH_ID
									: wssid_pkg::PH_VALUE;
							end
						end
						wssid_pkg::PH_VALUE: begin
							rem_dec = rem_d - 8'd1;
							rem_d   = rem_dec;
							if (eid_d == wssid_pkg::EID_SSID) begin
								have_char = 1'b1;
								ch        = wssid_pkg::printable(byte_s1);
							end
							if (rem_dec == 8'd0) begin
								if (eid_d == wssid_pkg::EID_SSID) begin
									found_d = 1'b1;
									phase_d = wssid_pkg::PH_DONE;
								end else begin
									phase_d = wssid_pkg::PH_ID;
								end
							end
						end
						wssid_pkg::PH_DONE: begin
							phase_d = wssid_pkg::PH_DONE;
						end
						default: begin
							phase_d = phase_d;
						end
					endcase
				end
				pos_d = pos_q + PW'(1);
			end

			if (last_s1) begin
				cls_sum = class_d;
				if (mseen_d && (pos_d < PW'(wssid_pkg::BODY_PROBE_REQ) ||
					(class_d == wssid_pkg::CLS_BEACON && pos_d < PW'(wssid_pkg::BODY_BEACON))))
					cls_sum = wssid_pkg::CLS_SHORT;
				emit      = 1'b1;
				kind_d    = wssid_pkg::KIND_SUMMARY;
				char_d    = have_char ? ch : 8'd0;
				cls_out_d = cls_sum;
				if (cls_sum == wssid_pkg::CLS_PROBE_REQ || cls_sum == wssid_pkg::CLS_BEACON) begin
					addr_out_d  = addr_d;
					found_out_d = found_d;
					len_out_d   = found_d ? slen_d : 8'd0;
				end
				pos_d = '0;
			end else if (have_char) begin
				emit       = 1'b1;
				kind_d     = wssid_pkg::KIND_CHAR;
				char_d     = ch;
				cls_out_d  = class_d;
				addr_out_d = addr_d;
			end
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame.ready) begin
			valid_s1 <= frame.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame.valid && frame.ready) begin
			byte_s1 <= frame.frame_byte;
			last_s1 <= frame.last_byte;
			mgmt_s1 <= frame.mgmt_packet;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_we) begin
			enable_q <= cfg_data;
		end
	end

	// frame state: advance once per parsed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			class_q <= wssid_pkg::CLS_IGNORED;
			addr_q  <= '0;
			phase_q <= wssid_pkg::PH_ID;
			eid_q   <= '0;
			rem_q   <= '0;
			found_q <= 1'b0;
			slen_q  <= '0;
			count_q <= '0;
			mseen_q <= 1'b0;
		end else if (advance) begin
			pos_q   <= pos_d;
			class_q <= class_d;
			addr_q  <= addr_d;
			phase_q <= phase_d;
			eid_q   <= eid_d;
			rem_q   <= rem_d;
			found_q <= found_d;
			slen_q  <= slen_d;
			count_q <= count_d;
			mseen_q <= mseen_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q      <= kind_d;
			char_q      <= char_d;
			cls_out_q   <= cls_out_d;
			addr_out_q  <= addr_out_d;
			found_out_q <= found_out_d;
			len_out_q   <= len_out_d;
			count_out_q <= count_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.result_kind  = kind_q;
	assign result.ssid_char    = char_q;
	assign result.frame_class  = cls_out_q;
	assign result.source_addr  = addr_out_q;
	assign result.ssid_found   = found_out_q;
	assign result.ssid_length  = len_out_q;
	assign result.packet_count = count_out_q;

endmodule

>>> dv/wlan_mgmt_frame_ssid_extractor_tb.sv
// Self-checking testbench for wlan_mgmt_frame_ssid_extractor: directed and random frames,
// with a byte-level predictor of classification, address capture and the SSID walk.
// Depends on wssid_pkg, the channel interfaces in wssid_if.sv and the block itself.
`timescale 1ns / 1ps

module wlan_mgmt_frame_ssid_extractor_tb;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_PHASE_ITEMS = 350;

	typedef struct {
		wssid_pkg::result_kind_t kind;
		logic [7:0]              ch;
		wssid_pkg::frame_class_t cls;
		logic [47:0]             addr;
		logic                    found;
		logic [7:0]              len;
		logic [31:0]             count;
	} ssid_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_data;

	wssid_frame_if  frame_ch ();
	wssid_result_if result_ch ();

	wlan_mgmt_frame_ssid_extractor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.frame    (frame_ch),
		.result   (result_ch)
	);

	// predictor state
	logic                        sniff_on;
	logic [wssid_pkg::POS_W-1:0] frame_pos;
	wssid_pkg::frame_class_t     cur_class;
	logic [47:0]                 cur_addr;
	wssid_pkg::elem_phase_t      ie_phase;
	logic [7:0]                  ie_id;
	logic [7:0]                  ie_left;
	logic                        ssid_done;
	logic [7:0]                  ssid_len;
	logic [31:0]                 mgmt_count;
	logic                        mgmt_tag;

	ssid_result_t pending_results[$];
	logic [7:0]   frame_bytes[$];

	int fail_count;
	int items_sent;
	int cycle_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_request;
	int hold_left;
	int stall_left;

	always #5 clk = ~clk;

	function automatic int idle_length(input int pct);
		int r;
		if ($urandom_range(99) >= pct)
			return 0;
		r = $urandom_range(99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endfunction

	task automatic clear_frame_state();
		frame_pos = '0;
		cur_class = wssid_pkg::CLS_IGNORED;
		cur_addr  = '0;
		ie_phase  = wssid_pkg::PH_ID;
		ie_id     = '0;
		ie_left   = '0;
		ssid_done = 1'b0;
		ssid_len  = '0;
		mgmt_tag  = 1'b0;
	endtask

	// Advance the predictor by one accepted byte and queue what it produces.
	task automatic parse_byte(input logic [7:0] b, input logic last, input logic mg);
		ssid_result_t            r;
		logic                    have_char;
		logic [7:0]              ch;
		int                      body;
		wssid_pkg::frame_class_t summ_cls;
		have_char = 1'b0;
		ch = '0;
		if (!sniff_on) begin
			frame_pos = '0;
			return;
		end
		if (frame_pos == 0) begin
			clear_frame_state();
			mgmt_tag = mg;
			if (mg) begin
				mgmt_count++;
				if (b[3:2] == wssid_pkg::FTYPE_MGMT) begin
					if (b[7:4] == wssid_pkg::SUBTYPE_PROBE_REQ)
						cur_class = wssid_pkg::CLS_PROBE_REQ;
					else if (b[7:4] == wssid_pkg::SUBTYPE_PROBE_RSP ||
							b[7:4] == wssid_pkg::SUBTYPE_BEACON)
						cur_class = wssid_pkg::CLS_BEACON;
				end
			end
		end
		if (frame_pos < wssid_pkg::MAX_FRAME_BYTES) begin
			if (frame_pos >= wssid_pkg::ADDR_FIRST && frame_pos <= wssid_pkg::ADDR_LAST)
				cur_addr = {cur_addr[39:0], b};
			if (cur_class == wssid_pkg::CLS_PROBE_REQ || cur_class == wssid_pkg::CLS_BEACON)
					begin
				body = (cur_class == wssid_pkg::CLS_PROBE_REQ) ? wssid_pkg::BODY_PROBE_REQ :
					wssid_pkg::BODY_BEACON;
				if (frame_pos >= body) begin
					case (ie_phase)
						wssid_pkg::PH_ID: begin
							ie_id = b;
							ie_phase = wssid_pkg::PH_LEN;
						end
						wssid_pkg::PH_LEN: begin
							ie_left = b;
							if (ie_id == wssid_pkg::EID_SSID) begin
								ssid_len = b;
								if (b == 0) begin
									ssid_done = 1'b1;
									ie_phase = wssid_pkg::PH_DONE;
								end else begin
									ie_phase = wssid_pkg::PH_VALUE;
								end
							end else begin
								ie_phase = (b == 0) ? wssid_pkg::PH_ID : wssid_pkg::PH_VALUE;
							end
						end
						wssid_pkg::PH_VALUE: begin
							ie_left = ie_left - 8'd1;
							if (ie_id == wssid_pkg::EID_SSID) begin
								have_char = 1'b1;
								ch = (b < wssid_pkg::CHAR_LOW || b > wssid_pkg::CHAR_HIGH) ?
									wssid_pkg::CHAR_SUBST : b;
							end
							if (ie_left == 0) begin
								if (ie_id == wssid_pkg::EID_SSID) begin
									ssid_done = 1'b1;
									ie_phase = wssid_pkg::PH_DONE;
								end else begin
									ie_phase = wssid_pkg::PH_ID;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			frame_pos++;
		end
		if (last) begin
			summ_cls = cur_class;
			if (mgmt_tag && (frame_pos < wssid_pkg::BODY_PROBE_REQ ||
					(cur_class == wssid_pkg::CLS_BEACON && frame_pos < wssid_pkg::BODY_BEACON)))
				summ_cls = wssid_pkg::CLS_SHORT;
			r.kind  = wssid_pkg::KIND_SUMMARY;
			r.ch    = ch;
			r.cls   = summ_cls;
			r.count = mgmt_count;
			if (summ_cls == wssid_pkg::CLS_PROBE_REQ || summ_cls == wssid_pkg::CLS_BEACON) begin
				r.addr  = cur_addr;
				r.found = ssid_done;
				r.len   = ssid_done ? ssid_len : 8'd0;
			end else begin
				r.addr  = '0;
				r.found = 1'b0;
				r.len   = '0;
			end
			pending_results.push_back(r);
			frame_pos = '0;
		end else if (have_char) begin
			r.kind  = wssid_pkg::KIND_CHAR;
			r.ch    = ch;
			r.cls   = cur_class;
			r.addr  = cur_addr;
			r.found = 1'b0;
			r.len   = '0;
			r.count = mgmt_count;
			pending_results.push_back(r);
		end
	endtask

	// Offer one byte after a random gap and hold it until the block takes it.
	task automatic send_byte(input logic [7:0] b, input logic last, input logic mg);
		int gap;
		gap = idle_length(send_idle_pct);
		if (gap > 0) begin
			frame_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		frame_ch.valid       <= 1'b1;
		frame_ch.frame_byte  <= b;
		frame_ch.last_byte   <= last;
		frame_ch.mgmt_packet <= mg;
		do
			@(posedge clk);
		while (!frame_ch.ready);
		parse_byte(b, last, mg);
		if (sniff_on)
			items_sent++;
	endtask

	task automatic wait_drained();
		frame_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// let a byte with no result clear the pipeline too
		repeat (6) @(posedge clk);
	endtask

	task automatic write_enable(input logic value);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sniff_on = value;
	endtask

	task automatic start_frame(input logic [7:0] fc, input int hdr_len);
		frame_bytes.delete();
		frame_bytes.push_back(fc);
		repeat (hdr_len - 1)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_element(input logic [7:0] id, input int len);
		frame_bytes.push_back(id);
		frame_bytes.push_back(8'(len));
		repeat (len)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(input logic mg, input logic ends);
		int   i;
		logic tag;
		for (i = 0; i < frame_bytes.size(); i++) begin
			tag = (i == 0) ? mg : ($urandom_range(0, 1) == 1);
			send_byte(frame_bytes[i], ends && (i == frame_bytes.size() - 1), tag);
		end
	endtask

	task automatic random_noise();
		repeat ($urandom_range(1, 6))
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
				$urandom_range(0, 1) == 1);
	endtask

	task automatic random_frame();
		int         sel;
		int         keep;
		logic [7:0] fc;
		logic       mg;
		sel = $urandom_range(99);
		fc = 8'($urandom_range(0, 255));
		if (sel < 40)
			fc[7:2] = {wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT};
		else if (sel < 60)
			fc[7:2] = {wssid_pkg::SUBTYPE_PROBE_RSP, wssid_pkg::FTYPE_MGMT};
		else if (sel < 80)
			fc[7:2] = {wssid_pkg::SUBTYPE_BEACON, wssid_pkg::FTYPE_MGMT};
		mg = ($urandom_range(9) != 0);
		start_frame(fc, (fc[7:4] == wssid_pkg::SUBTYPE_PROBE_REQ) ?
			wssid_pkg::BODY_PROBE_REQ : wssid_pkg::BODY_BEACON);
		repeat ($urandom_range(0, 2))
			add_element(8'($urandom_range(1, 255)), $urandom_range(0, 6));
		if ($urandom_range(9) != 0)
			add_element(wssid_pkg::EID_SSID, ($urandom_range(99) < 5) ?
				$urandom_range(33, 255) : $urandom_range(0, 32));
		repeat ($urandom_range(0, 2))
			add_element(8'($urandom_range(0, 255)), $urandom_range(0, 6));
		// cut some frames short at a random byte, in the header or the elements
		if ($urandom_range(99) < 15) begin
			keep = $urandom_range(1, frame_bytes.size());
			while (frame_bytes.size() > keep)
				void'(frame_bytes.pop_back());
		end
		send_frame(mg, 1'b1);
	endtask

	task automatic test_disabled();
		repeat (4)
			send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1, 1'b1);
		write_enable(1'b1);
	endtask

	task automatic test_short_frames();
		start_frame({wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT, 2'b00}, 1);
		send_frame(1'b1, 1'b1);
		start_frame(8'hFF, 1);
		send_frame(1'b0, 1'b1);
		start_frame({wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_PROBE_REQ - 1);
		send_frame(1'b1, 1'b1);
		start_frame({wssid_pkg::SUBTYPE_BEACON, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_BEACON - 1);
		send_frame(1'b1, 1'b1);
		start_frame({wssid_pkg::SUBTYPE_BEACON, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_BEACON);
		send_frame(1'b1, 1'b1);
		start_frame({wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_PROBE_REQ);
		send_frame(1'b1, 1'b1);
		// data frame type, long enough not to count as short
		start_frame(8'h08, 30);
		send_frame(1'b1, 1'b1);
	endtask

	task automatic test_ssid_elements();
		logic [7:0] odd_chars[8];
		odd_chars = '{8'd0, 8'd31, 8'd32, 8'd65, 8'd126, 8'd127, 8'd200, 8'd255};
		// wildcard SSID, frame ends on its length byte
		start_frame({wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT, 2'b11},
			wssid_pkg::BODY_PROBE_REQ);
		add_element(wssid_pkg::EID_SSID, 0);
		send_frame(1'b1, 1'b1);
		start_frame({wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT, 2'b01},
			wssid_pkg::BODY_PROBE_REQ);
		add_element(wssid_pkg::EID_SSID, 0);
		add_element(8'd1, 2);
		send_frame(1'b1, 1'b1);
		// empty and filled elements ahead of the SSID, a second SSID after it
		start_frame({wssid_pkg::SUBTYPE_PROBE_RSP, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_BEACON);
		add_element(8'd3, 0);
		add_element(8'd221, 3);
		frame_bytes.push_back(wssid_pkg::EID_SSID);
		frame_bytes.push_back(8'd8);
		foreach (odd_chars[i])
			frame_bytes.push_back(odd_chars[i]);
		add_element(wssid_pkg::EID_SSID, 2);
		send_frame(1'b1, 1'b1);
		// last SSID character rides in the summary
		start_frame({wssid_pkg::SUBTYPE_BEACON, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_BEACON);
		add_element(wssid_pkg::EID_SSID, 3);
		send_frame(1'b1, 1'b1);
		// SSID cut off by the frame end
		start_frame({wssid_pkg::SUBTYPE_BEACON, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_BEACON);
		add_element(wssid_pkg::EID_SSID, 5);
		repeat (3)
			void'(frame_bytes.pop_back());
		send_frame(1'b1, 1'b1);
		// probe request layout without the management tag
		start_frame({wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_PROBE_REQ);
		add_element(wssid_pkg::EID_SSID, 2);
		send_frame(1'b0, 1'b1);
	endtask

	task automatic test_abandoned_frame();
		start_frame({wssid_pkg::SUBTYPE_BEACON, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_BEACON);
		add_element(wssid_pkg::EID_SSID, 10);
		repeat (6)
			void'(frame_bytes.pop_back());
		send_frame(1'b1, 1'b0);
		write_enable(1'b0);
		repeat (3)
			send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		write_enable(1'b1);
		start_frame({wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_PROBE_REQ);
		add_element(wssid_pkg::EID_SSID, 4);
		send_frame(1'b1, 1'b1);
		// toggle enable with no bytes in between: the open frame carries on
		start_frame({wssid_pkg::SUBTYPE_PROBE_REQ, wssid_pkg::FTYPE_MGMT, 2'b00}, 12);
		send_frame(1'b1, 1'b0);
		write_enable(1'b0);
		write_enable(1'b1);
		frame_bytes.delete();
		repeat (12)
			frame_bytes.push_back(8'($urandom_range(0, 255)));
		add_element(wssid_pkg::EID_SSID, 3);
		send_frame(1'b0, 1'b1);
	endtask

	task automatic test_overlong_frame();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		start_frame({wssid_pkg::SUBTYPE_BEACON, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_BEACON);
		repeat (15)
			add_element(8'd221, 255);
		// this element ends exactly at the parse limit; an SSID follows past it
		add_element(8'd221, 202);
		add_element(wssid_pkg::EID_SSID, 3);
		send_frame(1'b1, 1'b1);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 400;
		// one-byte frames each give a summary, so the block backs up quickly
		repeat (40) begin
			start_frame(8'($urandom_range(0, 255)), 1);
			send_frame($urandom_range(0, 1) == 1, 1'b1);
		end
		start_frame({wssid_pkg::SUBTYPE_BEACON, wssid_pkg::FTYPE_MGMT, 2'b00},
			wssid_pkg::BODY_BEACON);
		add_element(wssid_pkg::EID_SSID, 32);
		send_frame(1'b1, 1'b1);
	endtask

	task automatic test_random_traffic();
		int phase;
		int phase_start;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 30;
					recv_stall_pct = 30;
				end
				1: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 60;
					recv_stall_pct = 10;
				end
				default: begin
					send_idle_pct = 10;
					recv_stall_pct = 60;
				end
			endcase
			if (phase == 2) begin
				write_enable(1'b0);
				random_noise();
				write_enable(1'b1);
			end
			phase_start = items_sent;
			while (items_sent - phase_start < RANDOM_PHASE_ITEMS) begin
				if ($urandom_range(99) < 88)
					random_frame();
				else
					random_noise();
			end
		end
	endtask

	// receiver: random stalls, plus a long hold when a test asks for one
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			stall_left = idle_length(recv_stall_pct);
			result_ch.ready <= (stall_left == 0);
			if (stall_left > 0)
				stall_left--;
		end
	end

	always @(posedge clk) begin
		ssid_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: kind %0d char %02h class %0d count %0d",
					result_ch.result_kind, result_ch.ssid_char, result_ch.frame_class,
					result_ch.packet_count));
			end else begin
				want = pending_results.pop_front();
				if (result_ch.result_kind !== want.kind || result_ch.ssid_char !== want.ch ||
						result_ch.frame_class !== want.cls ||
						result_ch.source_addr !== want.addr ||
						result_ch.ssid_found !== want.found ||
						result_ch.ssid_length !== want.len ||
						result_ch.packet_count !== want.count)
					note_failure($sformatf({"mismatch: expected kind %0d char %02h class %0d ",
						"addr %012h found %0d len %0d count %0d, got kind %0d char %02h ",
						"class %0d addr %012h found %0d len %0d count %0d"},
						want.kind, want.ch, want.cls, want.addr, want.found, want.len,
						want.count, result_ch.result_kind, result_ch.ssid_char,
						result_ch.frame_class, result_ch.source_addr, result_ch.ssid_found,
						result_ch.ssid_length, result_ch.packet_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("wlan_mgmt_frame_ssid_extractor_tb: done, errors");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = 1'b0;
		frame_ch.valid = 1'b0;
		frame_ch.frame_byte = '0;
		frame_ch.last_byte = 1'b0;
		frame_ch.mgmt_packet = 1'b0;
		result_ch.ready = 1'b0;
		fail_count = 0;
		items_sent = 0;
		cycle_count = 0;
		hold_request = 0;
		hold_left = 0;
		stall_left = 0;
		send_idle_pct = 20;
		recv_stall_pct = 20;
		sniff_on = 1'b0;
		mgmt_count = '0;
		clear_frame_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled();
		test_short_frames();
		test_ssid_elements();
		test_abandoned_frame();
		test_overlong_frame();
		test_backpressure();
		test_random_traffic();
		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("wlan_mgmt_frame_ssid_extractor_tb: done, clean");
		else
			$display("wlan_mgmt_frame_ssid_extractor_tb: done, errors");
		$finish;
	end

endmodule
